[sv/aipc_pkg.sv]
// Shared types, codes and microcode program of the impact peak counter.
`timescale 1ns / 1ps
`default_nettype none

package aipc_pkg;

    localparam int AXIS_W  = 13;
    localparam int MAG_W   = 13;
    localparam int CNT_W   = 16;
    localparam int SQ_W    = 26;
    localparam int REM_W   = 16;
    localparam int STEP_W  = 4;
    localparam int SEL_W   = 4;
    localparam int ITER_W  = 4;
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    localparam logic [MAG_W-1:0]   THR_RESET    = 13'd2000;
    localparam logic [CNT_W-1:0]   CNT_MAX      = 16'hFFFF;
    localparam logic [ITER_W-1:0]  ROOT_ITERS_M1 = 4'd12;
    localparam logic [PADDR_W-1:0] ADDR_THR     = 2'd0;

    localparam logic [1:0] ACT_BATCH = 2'd0;
    localparam logic [1:0] ACT_INC   = 2'd1;
    localparam logic [1:0] ACT_DEC   = 2'd2;

    localparam logic [1:0] ACC_NONE = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    localparam logic [1:0] MAX_NONE = 2'd0;
    localparam logic [1:0] MAX_INIT = 2'd1;
    localparam logic [1:0] MAX_CMP  = 2'd2;

    localparam logic [1:0] SQ_NONE = 2'd0;
    localparam logic [1:0] SQ_INIT = 2'd1;
    localparam logic [1:0] SQ_ITER = 2'd2;

    localparam logic [2:0] BR_NEXT     = 3'd0;
    localparam logic [2:0] BR_WAIT_IN  = 3'd1;
    localparam logic [2:0] BR_BUTTON   = 3'd2;
    localparam logic [2:0] BR_LOOP     = 3'd3;
    localparam logic [2:0] BR_WAIT_OUT = 3'd4;
    localparam logic [2:0] BR_JUMP     = 3'd5;

    localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_BUTTON = 4'd12;
    localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd13;

    typedef struct packed {
        logic [1:0]        action;
        logic [AXIS_W-1:0] ax0;
        logic [AXIS_W-1:0] ay0;
        logic [AXIS_W-1:0] az0;
        logic [AXIS_W-1:0] ax1;
        logic [AXIS_W-1:0] ay1;
        logic [AXIS_W-1:0] az1;
        logic [AXIS_W-1:0] ax2;
        logic [AXIS_W-1:0] ay2;
        logic [AXIS_W-1:0] az2;
    } aipc_in_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [MAG_W-1:0] peak_value;
        logic             hit;
        logic [CNT_W-1:0] event_count;
    } aipc_out_t;

    typedef struct packed {
        logic             load_in;
        logic             mul_en;
        logic [SEL_W-1:0] sel;
        logic [1:0]       acc_op;
        logic [1:0]       max_op;
        logic [1:0]       sq_op;
        logic             upd;
        logic             btn;
        logic             emit;
    } ctrl_t;

    typedef struct packed {
        ctrl_t             ctrl;
        logic [2:0]        br;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic button;
        logic iter_zero;
        logic out_free;
    } status_t;

    function automatic ucode_t uc(input logic ld, input logic mul, input logic [SEL_W-1:0] sel,
                                  input logic [1:0] acc, input logic [1:0] mx,
                                  input logic [1:0] sq, input logic upd, input logic btn,
                                  input logic emit, input logic [2:0] br,
                                  input logic [STEP_W-1:0] tgt);
        ucode_t w;
        w.ctrl.load_in = ld;
        w.ctrl.mul_en  = mul;
        w.ctrl.sel     = sel;
        w.ctrl.acc_op  = acc;
        w.ctrl.max_op  = mx;
        w.ctrl.sq_op   = sq;
        w.ctrl.upd     = upd;
        w.ctrl.btn     = btn;
        w.ctrl.emit    = emit;
        w.br           = br;
        w.target       = tgt;
        return w;
    endfunction

    // Program: square and accumulate, running axis maximum, 13 root iterations, update, button step, emit.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            4'd0:  w = uc(1'b1, 1'b0, 4'd0, ACC_NONE, MAX_NONE, SQ_NONE, 1'b0, 1'b0, 1'b0,
                          BR_WAIT_IN, STEP_IDLE);
            4'd1:  w = uc(1'b0, 1'b1, 4'd0, ACC_NONE, MAX_INIT, SQ_NONE, 1'b0, 1'b0, 1'b0,
                          BR_BUTTON, STEP_BUTTON);
            4'd2:  w = uc(1'b0, 1'b1, 4'd1, ACC_LOAD, MAX_CMP, SQ_NONE, 1'b0, 1'b0, 1'b0,
                          BR_NEXT, STEP_IDLE);
            4'd3:  w = uc(1'b0, 1'b1, 4'd2, ACC_ADD, MAX_CMP, SQ_NONE, 1'b0, 1'b0, 1'b0,
                          BR_NEXT, STEP_IDLE);
            4'd4:  w = uc(1'b0, 1'b0, 4'd3, ACC_ADD, MAX_CMP, SQ_NONE, 1'b0, 1'b0, 1'b0,
                          BR_NEXT, STEP_IDLE);
            4'd5:  w = uc(1'b0, 1'b0, 4'd4, ACC_NONE, MAX_CMP, SQ_INIT, 1'b0, 1'b0, 1'b0,
                          BR_NEXT, STEP_IDLE);
            4'd6:  w = uc(1'b0, 1'b0, 4'd5, ACC_NONE, MAX_CMP, SQ_ITER, 1'b0, 1'b0, 1'b0,
                          BR_NEXT, STEP_IDLE);
            4'd7:  w = uc(1'b0, 1'b0, 4'd6, ACC_NONE, MAX_CMP, SQ_ITER, 1'b0, 1'b0, 1'b0,
                          BR_NEXT, STEP_IDLE);
            4'd8:  w = uc(1'b0, 1'b0, 4'd7, ACC_NONE, MAX_CMP, SQ_ITER, 1'b0, 1'b0, 1'b0,
                          BR_NEXT, STEP_IDLE);
            4'd9:  w = uc(1'b0, 1'b0, 4'd8, ACC_NONE, MAX_CMP, SQ_ITER, 1'b0, 1'b0, 1'b0,
                          BR_NEXT, STEP_IDLE);
            4'd10: w = uc(1'b0, 1'b0, 4'd0, ACC_NONE, MAX_NONE, SQ_ITER, 1'b0, 1'b0, 1'b0,
                          BR_LOOP, STEP_IDLE);
            4'd11: w = uc(1'b0, 1'b0, 4'd0, ACC_NONE, MAX_NONE, SQ_NONE, 1'b1, 1'b0, 1'b0,
                          BR_JUMP, STEP_EMIT);
            4'd12: w = uc(1'b0, 1'b0, 4'd0, ACC_NONE, MAX_NONE, SQ_NONE, 1'b0, 1'b1, 1'b0,
                          BR_NEXT, STEP_IDLE);
            4'd13: w = uc(1'b0, 1'b0, 4'd0, ACC_NONE, MAX_NONE, SQ_NONE, 1'b0, 1'b0, 1'b1,
                          BR_WAIT_OUT, STEP_IDLE);
            default: w = uc(1'b0, 1'b0, 4'd0, ACC_NONE, MAX_NONE, SQ_NONE, 1'b0, 1'b0, 1'b0,
                            BR_JUMP, STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[sv/aipc_seq.sv]
// Microcode sequencer: step counter, program ROM and branch logic.
`timescale 1ns / 1ps
`default_nettype none

module aipc_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire aipc_pkg::status_t status,
    output aipc_pkg::ctrl_t      ctrl
);
    import aipc_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] step_inc;
    ucode_t            word;

    assign word     = ucode_rom(step_reg);
    assign ctrl     = word.ctrl;
    assign step_inc = step_reg + 1'b1;

    always_comb
    begin
        case (word.br)
            BR_NEXT:     step_next = step_inc;
            BR_WAIT_IN:  step_next = status.in_valid ? step_inc : step_reg;
            BR_BUTTON:   step_next = status.button ? word.target : step_inc;
            BR_LOOP:     step_next = status.iter_zero ? step_inc : step_reg;
            BR_WAIT_OUT: step_next = status.out_free ? word.target : step_reg;
            BR_JUMP:     step_next = word.target;
            default:     step_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

[sv/aipc_sqrt.sv]
// Restoring floor square root, one root bit per iteration.
`timescale 1ns / 1ps
`default_nettype none

module aipc_sqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [1:0]                 sq_op,
    input  wire logic [aipc_pkg::SQ_W-1:0]  radicand,
    output logic      [aipc_pkg::MAG_W-1:0] root,
    output logic                            iter_zero
);
    import aipc_pkg::*;

    logic [SQ_W-1:0]   rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [MAG_W-1:0]  root_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    assign rem_sh    = {rem_reg[REM_W-3:0], rad_reg[SQ_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign take      = (rem_sh >= trial);
    assign root      = root_reg;
    assign iter_zero = (cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        case (sq_op)
            SQ_INIT:
            begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            SQ_ITER:
            begin
                rad_reg  <= {rad_reg[SQ_W-3:0], 2'b00};
                rem_reg  <= take ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_reg[MAG_W-2:0], take};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (sq_op == SQ_INIT)
        begin
            cnt_reg <= ROOT_ITERS_M1;
        end
        else if (sq_op == SQ_ITER && cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

[sv/aipc_dp.sv]
// Datapath: input beat, squarer, accumulator, axis maximum, state and output register.
`timescale 1ns / 1ps
`default_nettype none

module aipc_dp (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire aipc_pkg::ctrl_t            ctrl,
    input  wire logic                       in_valid,
    input  wire aipc_pkg::aipc_in_t         in_data,
    input  wire logic [aipc_pkg::MAG_W-1:0] threshold,
    input  wire logic                       out_ready,
    output logic                            out_valid,
    output aipc_pkg::aipc_out_t             out_data,
    output aipc_pkg::status_t               status
);
    import aipc_pkg::*;

    aipc_in_t                 in_reg;
    logic signed [AXIS_W-1:0] axis;
    logic signed [SQ_W-1:0]   prod_full;
    logic [SQ_W-1:0]          prod_reg;
    logic [SQ_W-1:0]          acc_reg;
    logic signed [AXIS_W-1:0] best_reg;
    logic [MAG_W-1:0]         root;
    logic                     iter_zero;
    logic [MAG_W-1:0]         peak_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [MAG_W-1:0]         mag_res_reg;
    logic                     hit_res_reg;
    aipc_out_t                out_reg;
    logic                     out_valid_reg;
    logic                     out_free;
    logic [MAG_W-1:0]         peak_mag;
    logic [MAG_W-1:0]         best_u;
    logic                     best_wins;
    logic                     hit;
    logic                     cnt_full;

    always_comb
    begin
        case (ctrl.sel)
            4'd0:    axis = in_reg.ax0;
            4'd1:    axis = in_reg.ay0;
            4'd2:    axis = in_reg.az0;
            4'd3:    axis = in_reg.ax1;
            4'd4:    axis = in_reg.ay1;
            4'd5:    axis = in_reg.az1;
            4'd6:    axis = in_reg.ax2;
            4'd7:    axis = in_reg.ay2;
            4'd8:    axis = in_reg.az2;
            default: axis = '0;
        endcase
    end

    assign prod_full = axis * axis;

    assign peak_mag  = (root > peak_reg) ? root : peak_reg;
    assign best_u    = {1'b0, best_reg[AXIS_W-2:0]};
    assign best_wins = !best_reg[AXIS_W-1] && (best_u > peak_mag);
    assign hit       = (root > threshold);
    assign cnt_full  = (count_reg == CNT_MAX);
    assign out_free  = !out_valid_reg || out_ready;

    assign status.in_valid  = in_valid;
    assign status.button    = (in_reg.action != ACT_BATCH);
    assign status.iter_zero = iter_zero;
    assign status.out_free  = out_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    aipc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .sq_op     (ctrl.sq_op),
        .radicand  (acc_reg),
        .root      (root),
        .iter_zero (iter_zero)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.load_in && in_valid)
        begin
            in_reg <= in_data;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_full;
        end
        case (ctrl.acc_op)
            ACC_LOAD: acc_reg <= prod_reg;
            ACC_ADD:  acc_reg <= acc_reg + prod_reg;
            default:  acc_reg <= acc_reg;
        endcase
        case (ctrl.max_op)
            MAX_INIT: best_reg <= axis;
            MAX_CMP:  best_reg <= (axis > best_reg) ? axis : best_reg;
            default:  best_reg <= best_reg;
        endcase
        if (ctrl.upd)
        begin
            mag_res_reg <= root;
            hit_res_reg <= hit;
        end
        else if (ctrl.btn)
        begin
            mag_res_reg <= '0;
            hit_res_reg <= 1'b0;
        end
        if (ctrl.emit && out_free)
        begin
            out_reg.magnitude   <= mag_res_reg;
            out_reg.peak_value  <= peak_reg;
            out_reg.hit         <= hit_res_reg;
            out_reg.event_count <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.upd)
            begin
                peak_reg <= best_wins ? best_u : peak_mag;
                if (hit && !cnt_full)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            else if (ctrl.btn)
            begin
                if (in_reg.action == ACT_INC && !cnt_full)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                else if (in_reg.action == ACT_DEC && count_reg != '0)
                begin
                    count_reg <= count_reg - 1'b1;
                end
            end
            if (ctrl.emit && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[sv/accel_impact_peak_counter.sv]
// Impact peak counter top level: configuration port, sequencer and datapath.
//
// Usage: one input beat on in_valid/in_ready carries an action and three
// 3-axis samples. A batch beat (action 0) yields the floor root of the first
// sample's squared magnitude, updates the held peak with it and with the
// largest of the nine axis values, and counts a hit when the magnitude is
// above hit_threshold. Actions 1 and 2 step the count up or down, action 3
// leaves it; a button beat reports zero magnitude and no hit. Every input
// beat gives exactly one output beat. A batch beat passes squaring,
// accumulation, the 13 iterations of the bit-per-cycle root unit and the
// update; a button beat passes the count step. The next input beat is taken
// once the result is emitted. hit_threshold lies at byte address 0 of the
// APB port; the user must see that it is written only while the block is
// idle, which the block itself does not enforce. Reset clears the peak and
// the count and loads a threshold of 2000. While the receiver stalls, the
// result holds in the output register; the block still takes and works on
// one further input beat and then waits before emitting it.
`timescale 1ns / 1ps
`default_nettype none

module accel_impact_peak_counter (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [aipc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [aipc_pkg::PDATA_W-1:0] pwdata,
    output logic      [aipc_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire aipc_pkg::aipc_in_t           in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output aipc_pkg::aipc_out_t               out_data
);
    import aipc_pkg::*;

    logic [MAG_W-1:0] thr_reg;
    ctrl_t            ctrl;
    status_t          status;

    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_THR) ? {{(PDATA_W-MAG_W){1'b0}}, thr_reg} : '0;
    assign in_ready = ctrl.load_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (psel && penable && pwrite && paddr == ADDR_THR)
        begin
            thr_reg <= pwdata[MAG_W-1:0];
        end
    end

    aipc_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    aipc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .threshold (thr_reg),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .status    (status)
    );

endmodule

`default_nettype wire

[sv/aipc_chk.sv]
// Port-level checks for the impact peak counter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module aipc_chk (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire aipc_pkg::aipc_out_t          out_data
);
    import aipc_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // one item at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in work");

    a_peak_ge_mag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.peak_value >= out_data.magnitude)
        else $error("peak below magnitude");

    a_hit_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit |-> out_data.magnitude != '0 && out_data.event_count != '0)
        else $error("hit without magnitude or count");

endmodule

bind accel_impact_peak_counter aipc_chk u_aipc_chk (.*);

`default_nettype wire
